// ----- rtl/slwd_pkg.sv -----
package slwd_pkg;

  typedef enum logic [3:0] {
    K_IDLE     = 4'd0,
    K_BUSY_ON  = 4'd1,
    K_BUSY_OFF = 4'd2,
    K_TRAILER  = 4'd3,
    K_REGION   = 4'd4,
    K_CHIP_HDR = 4'd5,
    K_EMPTY    = 4'd6,
    K_SHORT    = 4'd7,
    K_LONG     = 4'd8,
    K_END      = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_NEED2   = 2'd1,
    PH_NEED3   = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    PK_CHIP_HDR = 2'd0,
    PK_EMPTY    = 2'd1,
    PK_SHORT    = 2'd2,
    PK_LONG     = 2'd3
  } pending_t;

  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [7:0] BYTE_BUSY_ON  = 8'hF1;
  localparam logic [7:0] BYTE_BUSY_OFF = 8'hF0;
  localparam logic [3:0] NIB_PAD       = 4'b0010;
  localparam logic [3:0] NIB_TRAILER   = 4'b1011;
  localparam logic [2:0] TOP3_REGION   = 3'b110;
  localparam logic [3:0] NIB_CHIP_HDR  = 4'b1010;
  localparam logic [3:0] NIB_EMPTY     = 4'b1110;
  localparam logic [1:0] TOP2_SHORT    = 2'b01;
  localparam logic [1:0] TOP2_LONG     = 2'b00;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       lane_last;
  } beat_t;

  typedef struct packed {
    kind_t       word_kind;
    logic [3:0]  header_nibble;
    logic [7:0]  bunch_byte;
    logic [4:0]  region_id;
    logic [3:0]  encoder_id;
    logic [9:0]  pixel_address;
    logic [6:0]  hit_map;
    logic [23:0] raw_word;
    logic        lane_end;
  } word_t;

endpackage

// ----- rtl/slwd_lane_if.sv -----
interface slwd_lane_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       lane_last;

  modport source (output valid, output data_byte, output lane_last, input ready);
  modport sink (input valid, input data_byte, input lane_last, output ready);
endinterface

// ----- rtl/slwd_word_if.sv -----
interface slwd_word_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_kind;
  logic [3:0]  header_nibble;
  logic [7:0]  bunch_byte;
  logic [4:0]  region_id;
  logic [3:0]  encoder_id;
  logic [9:0]  pixel_address;
  logic [6:0]  hit_map;
  logic [23:0] raw_word;
  logic        lane_end;

  modport source (
    output valid, output word_kind, output header_nibble, output bunch_byte,
    output region_id, output encoder_id, output pixel_address, output hit_map,
    output raw_word, output lane_end, input ready
  );
  modport sink (
    input valid, input word_kind, input header_nibble, input bunch_byte,
    input region_id, input encoder_id, input pixel_address, input hit_map,
    input raw_word, input lane_end, output ready
  );
endinterface

// ----- rtl/slwd_parser.sv -----
module slwd_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  slwd_pkg::beat_t beat,
  output logic           produced,
  output slwd_pkg::word_t word
);
  import slwd_pkg::*;

  phase_t     phase, phase_next;
  pending_t   pending, pending_next;
  logic [7:0] first_byte, first_byte_next;
  logic [7:0] second_byte, second_byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pending     <= pending_next;
      first_byte  <= first_byte_next;
      second_byte <= second_byte_next;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic       skip;
    b                = beat.data_byte;
    skip             = (b[7:4] == NIB_PAD) || (phase == PH_TRAILER);
    phase_next       = phase;
    pending_next     = pending;
    first_byte_next  = first_byte;
    second_byte_next = second_byte;
    produced         = 1'b0;
    word             = '0;
    word.word_kind   = K_IDLE;
    word.lane_end    = beat.lane_last;

    if (!skip) begin
      unique case (phase)
        PH_START: begin
          word.raw_word = {16'h0, b};
          if (b == BYTE_IDLE) begin
            word.word_kind = K_IDLE;
            produced       = 1'b1;
          end else if (b == BYTE_BUSY_ON) begin
            word.word_kind = K_BUSY_ON;
            produced       = 1'b1;
          end else if (b == BYTE_BUSY_OFF) begin
            word.word_kind = K_BUSY_OFF;
            produced       = 1'b1;
          end else if (b[7:4] == NIB_TRAILER) begin
            word.word_kind     = K_TRAILER;
            word.header_nibble = b[3:0];
            produced           = 1'b1;
            phase_next         = PH_TRAILER;
          end else if (b[7:5] == TOP3_REGION) begin
            word.word_kind = K_REGION;
            word.region_id = b[4:0];
            produced       = 1'b1;
          end else if (b[7:4] == NIB_CHIP_HDR) begin
            first_byte_next = b;
            pending_next    = PK_CHIP_HDR;
            phase_next      = PH_NEED2;
          end else if (b[7:4] == NIB_EMPTY) begin
            first_byte_next = b;
            pending_next    = PK_EMPTY;
            phase_next      = PH_NEED2;
          end else if (b[7:6] == TOP2_SHORT) begin
            first_byte_next = b;
            pending_next    = PK_SHORT;
            phase_next      = PH_NEED2;
          end else if (b[7:6] == TOP2_LONG) begin
            first_byte_next = b;
            pending_next    = PK_LONG;
            phase_next      = PH_NEED2;
          end
        end
        PH_NEED2: begin
          word.raw_word = {8'h0, first_byte, b};
          unique case (pending)
            PK_CHIP_HDR, PK_EMPTY: begin
              word.word_kind     = (pending == PK_CHIP_HDR) ? K_CHIP_HDR : K_EMPTY;
              word.header_nibble = first_byte[3:0];
              word.bunch_byte    = b;
              produced           = 1'b1;
              phase_next         = PH_START;
            end
            PK_SHORT: begin
              word.word_kind     = K_SHORT;
              word.encoder_id    = first_byte[5:2];
              word.pixel_address = {first_byte[1:0], b};
              produced           = 1'b1;
              phase_next         = PH_START;
            end
            PK_LONG: begin
              second_byte_next = b;
              phase_next       = PH_NEED3;
            end
            default: ;
          endcase
        end
        PH_NEED3: begin
          word.word_kind     = K_LONG;
          word.encoder_id    = first_byte[5:2];
          word.pixel_address = {first_byte[1:0], second_byte};
          word.hit_map       = b[6:0];
          word.raw_word      = {first_byte, second_byte, b};
          produced           = 1'b1;
          phase_next         = PH_START;
        end
        default: ;
      endcase
    end

    // last beat always reports and drops any partial word
    if (beat.lane_last) begin
      if (!produced) begin
        word           = '0;
        word.word_kind = K_END;
        word.lane_end  = 1'b1;
        produced       = 1'b1;
      end
      phase_next = PH_START;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    advance && beat.lane_last |=> phase == PH_START)
    else $error("parser not back at word start after lane end");

  a_last_reports: assert property (@(posedge clk) disable iff (rst)
    advance && beat.lane_last |-> produced)
    else $error("lane end beat gave no result");

  a_trailer_locks: assert property (@(posedge clk) disable iff (rst)
    advance && produced && word.word_kind == K_TRAILER && !beat.lane_last
    |=> phase == PH_TRAILER)
    else $error("trailer did not lock out the rest of the lane");

  a_end_is_empty: assert property (@(posedge clk) disable iff (rst)
    produced && word.word_kind == K_END |-> word.raw_word == '0 && word.lane_end)
    else $error("end-only result carries word bytes");

endmodule

// ----- rtl/slwd_out_reg.sv -----
module slwd_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  slwd_pkg::word_t word,
  output logic            free,
  slwd_word_if.source     words
);
  import slwd_pkg::*;

  logic  valid;
  word_t held;

  assign free = !valid || words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      held <= word;
    end
  end

  assign words.valid         = valid;
  assign words.word_kind     = held.word_kind;
  assign words.header_nibble = held.header_nibble;
  assign words.bunch_byte    = held.bunch_byte;
  assign words.region_id     = held.region_id;
  assign words.encoder_id    = held.encoder_id;
  assign words.pixel_address = held.pixel_address;
  assign words.hit_map       = held.hit_map;
  assign words.raw_word      = held.raw_word;
  assign words.lane_end      = held.lane_end;

endmodule

// ----- rtl/sensor_lane_word_decoder.sv -----
// channel  modport  beat carries
// lane     sink     data_byte, lane_last
// words    source   word_kind, header_nibble, bunch_byte, region_id, encoder_id,
//                   pixel_address, hit_map, raw_word, lane_end
//
// One byte a cycle sustained while words is not stalled; a byte's result reaches
// the words port through the input register and then the result register.
// The parse state advances only as a byte leaves the input register.
// Synchronous reset empties both registers and returns the parser to word start.
// A stall on words holds the result register; the input register then holds
// too, and lane.ready falls once both are full.
module sensor_lane_word_decoder (
  input logic         clk,
  input logic         rst,
  slwd_lane_if.sink   lane,
  slwd_word_if.source words
);
  import slwd_pkg::*;

  logic  in_valid;
  beat_t in_beat;
  logic  advance;
  logic  free;
  logic  produced;
  word_t word;

  assign advance    = in_valid && free;
  assign lane.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (lane.ready) begin
      in_valid <= lane.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane.ready && lane.valid) begin
      in_beat.data_byte <= lane.data_byte;
      in_beat.lane_last <= lane.lane_last;
    end
  end

  slwd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .beat     (in_beat),
    .produced (produced),
    .word     (word)
  );

  slwd_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (advance && produced),
    .word  (word),
    .free  (free),
    .words (words)
  );

endmodule

// ----- tb/sensor_lane_word_decoder_tb.sv -----
module sensor_lane_word_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slwd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LANE_TARGET = 520;
  localparam int NOISE_BYTES = 100;

  logic clk = 1'b0;
  logic rst;

  slwd_lane_if lane_bus ();
  slwd_word_if word_bus ();

  sensor_lane_word_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .lane  (lane_bus),
    .words (word_bus)
  );

  always #5 clk = ~clk;

  // decoder shadow state
  phase_t     lane_phase;
  pending_t   lane_pending;
  logic [7:0] lane_first;
  logic [7:0] lane_second;

  word_t      expected_words[$];
  logic [7:0] lane_q[$];
  int         mismatch_count;
  int         parsed_bytes;
  int         cycle_count;
  int         burst_left;
  bit         sender_steady;
  int         stall_pct;
  int         stall_left;

  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output word_t w);
    bit got;
    got = 1'b0;
    w = '0;
    if (b[7:4] == NIB_PAD || lane_phase == PH_TRAILER) begin
      got = 1'b0;
    end else if (lane_phase == PH_START) begin
      if (b == BYTE_IDLE) begin
        got = 1'b1; w.word_kind = K_IDLE;
      end else if (b == BYTE_BUSY_ON) begin
        got = 1'b1; w.word_kind = K_BUSY_ON;
      end else if (b == BYTE_BUSY_OFF) begin
        got = 1'b1; w.word_kind = K_BUSY_OFF;
      end else if (b[7:4] == NIB_TRAILER) begin
        got = 1'b1; w.word_kind = K_TRAILER; w.header_nibble = b[3:0];
        lane_phase = PH_TRAILER;
      end else if (b[7:5] == TOP3_REGION) begin
        got = 1'b1; w.word_kind = K_REGION; w.region_id = b[4:0];
      end else if (b[7:4] == NIB_CHIP_HDR) begin
        lane_first = b; lane_pending = PK_CHIP_HDR; lane_phase = PH_NEED2;
      end else if (b[7:4] == NIB_EMPTY) begin
        lane_first = b; lane_pending = PK_EMPTY; lane_phase = PH_NEED2;
      end else if (b[7:6] == TOP2_SHORT) begin
        lane_first = b; lane_pending = PK_SHORT; lane_phase = PH_NEED2;
      end else if (b[7:6] == TOP2_LONG) begin
        lane_first = b; lane_pending = PK_LONG; lane_phase = PH_NEED2;
      end
      if (got) w.raw_word = {16'h0000, b};
    end else if (lane_phase == PH_NEED2) begin
      if (lane_pending == PK_LONG) begin
        lane_second = b;
        lane_phase = PH_NEED3;
      end else begin
        got = 1'b1;
        w.raw_word = {8'h00, lane_first, b};
        if (lane_pending == PK_SHORT) begin
          w.word_kind = K_SHORT;
          w.encoder_id = lane_first[5:2];
          w.pixel_address = {lane_first[1:0], b};
        end else begin
          w.word_kind = (lane_pending == PK_CHIP_HDR) ? K_CHIP_HDR : K_EMPTY;
          w.header_nibble = lane_first[3:0];
          w.bunch_byte = b;
        end
        lane_phase = PH_START;
      end
    end else begin
      got = 1'b1;
      w.word_kind = K_LONG;
      w.encoder_id = lane_first[5:2];
      w.pixel_address = {lane_first[1:0], lane_second};
      w.hit_map = b[6:0];
      w.raw_word = {lane_first, lane_second, b};
      lane_phase = PH_START;
    end
    if (last) begin
      if (!got) begin
        got = 1'b1;
        w = '0;
        w.word_kind = K_END;
      end
      w.lane_end = 1'b1;
      lane_phase = PH_START;
      lane_pending = PK_CHIP_HDR;
      lane_first = '0;
      lane_second = '0;
    end
    return got;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    word_t w;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(6, 0);
      if (gap != 0) begin
        lane_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    lane_bus.valid     <= 1'b1;
    lane_bus.data_byte <= b;
    lane_bus.lane_last <= last;
    do @(posedge clk); while (!lane_bus.ready);
    if (b[7:4] != NIB_PAD && lane_phase != PH_TRAILER) parsed_bytes++;
    if (decode_byte(b, last, w)) expected_words = {expected_words, w};
  endtask

  function automatic void add_byte(input logic [7:0] x);
    lane_q = {lane_q, x};
  endfunction

  // send the collected lane, last byte flagged
  task automatic flush_lane();
    for (int i = 0; i < lane_q.size(); i++) send_byte(lane_q[i], i == lane_q.size() - 1);
    lane_q.delete();
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] x;
    do x = 8'($urandom); while (x[7:4] == NIB_PAD);
    return x;
  endfunction

  function automatic void push_word(input int sel);
    logic [7:0] x;
    case (sel)
      0: add_byte(BYTE_IDLE);
      1: add_byte(BYTE_BUSY_ON);
      2: add_byte(BYTE_BUSY_OFF);
      3: add_byte({TOP3_REGION, 5'($urandom)});
      4: begin
        add_byte({NIB_CHIP_HDR, 4'($urandom)});
        add_byte(body_byte());
      end
      5: begin
        add_byte({NIB_EMPTY, 4'($urandom)});
        add_byte(body_byte());
      end
      6: begin
        add_byte({TOP2_SHORT, 6'($urandom)});
        add_byte(body_byte());
      end
      default: begin
        do x = {TOP2_LONG, 6'($urandom)}; while (x[7:4] == NIB_PAD);
        add_byte(x);
        add_byte(body_byte());
        add_byte(body_byte());
      end
    endcase
  endfunction

  task automatic report(input string field, input logic [23:0] exp_v, input logic [23:0] act_v);
    $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    word_t w;
    if (!rst && word_bus.valid && word_bus.ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none actual kind %0h raw %0h",
                 $time, word_bus.word_kind, word_bus.raw_word);
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        if (word_bus.word_kind !== w.word_kind)
          report("word_kind", 24'(w.word_kind), 24'(word_bus.word_kind));
        if (word_bus.header_nibble !== w.header_nibble)
          report("header_nibble", 24'(w.header_nibble), 24'(word_bus.header_nibble));
        if (word_bus.bunch_byte !== w.bunch_byte)
          report("bunch_byte", 24'(w.bunch_byte), 24'(word_bus.bunch_byte));
        if (word_bus.region_id !== w.region_id)
          report("region_id", 24'(w.region_id), 24'(word_bus.region_id));
        if (word_bus.encoder_id !== w.encoder_id)
          report("encoder_id", 24'(w.encoder_id), 24'(word_bus.encoder_id));
        if (word_bus.pixel_address !== w.pixel_address)
          report("pixel_address", 24'(w.pixel_address), 24'(word_bus.pixel_address));
        if (word_bus.hit_map !== w.hit_map)
          report("hit_map", 24'(w.hit_map), 24'(word_bus.hit_map));
        if (word_bus.raw_word !== w.raw_word)
          report("raw_word", w.raw_word, word_bus.raw_word);
        if (word_bus.lane_end !== w.lane_end)
          report("lane_end", 24'(w.lane_end), 24'(word_bus.lane_end));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left != 0) begin
      word_bus.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      word_bus.ready <= 1'b0;
      stall_left = $urandom_range(7, 0);
    end else begin
      word_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sensor_lane_word_decoder: FAILED **");
      $finish;
    end
  end

  task automatic test_single_byte_words();
    send_byte(BYTE_IDLE, 1'b0);
    send_byte(BYTE_BUSY_ON, 1'b0);
    send_byte(BYTE_BUSY_OFF, 1'b1);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hDF, 1'b1);
  endtask

  // bytes after a trailer are ignored until the lane ends
  task automatic test_trailer();
    send_byte(8'hB5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hBA, 1'b1);
  endtask

  task automatic test_two_byte_words();
    send_byte(8'hA0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h40, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // second long word carries a pad byte inside
  task automatic test_long_words();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h2C, 1'b0);
    send_byte(8'hD5, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // unknown starts, pad as last byte, word cut short by lane end
  task automatic test_ignored_bytes();
    send_byte(8'h8F, 1'b0);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'h20, 1'b1);
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_random_lanes();
    int lane_count;
    int words;
    lane_count = 0;
    while (parsed_bytes < LANE_TARGET) begin
      // rotate pressure every few lanes, including calm stretches
      if (lane_count % 8 == 0) begin
        case ($urandom_range(2, 0))
          0: stall_pct = 0;
          1: stall_pct = 20;
          default: stall_pct = 60;
        endcase
        sender_steady = ($urandom_range(2, 0) == 0);
      end
      lane_count++;
      words = $urandom_range(6, 1);
      for (int i = 0; i < words; i++) begin
        if ($urandom_range(99, 0) < 6) begin
          add_byte({NIB_TRAILER, 4'($urandom)});
          repeat ($urandom_range(4, 0)) add_byte(8'($urandom));
          break;
        end
        push_word($urandom_range(7, 0));
        if ($urandom_range(99, 0) < 8) add_byte({NIB_PAD, 4'($urandom)});
      end
      // cut the lane inside a word now and then
      if ($urandom_range(99, 0) < 8) add_byte({NIB_CHIP_HDR, 4'($urandom)});
      flush_lane();
    end
  endtask

  task automatic test_random_noise();
    stall_pct = 40;
    sender_steady = 1'b0;
    for (int i = 0; i < NOISE_BYTES; i++)
      send_byte(8'($urandom), $urandom_range(7, 0) == 0);
  endtask

  initial begin
    rst = 1'b1;
    lane_bus.valid = 1'b0;
    lane_bus.data_byte = 8'h00;
    lane_bus.lane_last = 1'b0;
    word_bus.ready = 1'b0;
    lane_phase = PH_START;
    lane_pending = PK_CHIP_HDR;
    lane_first = '0;
    lane_second = '0;
    mismatch_count = 0;
    parsed_bytes = 0;
    cycle_count = 0;
    burst_left = 0;
    sender_steady = 1'b0;
    stall_pct = 30;
    stall_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_byte_words();
    test_trailer();
    test_two_byte_words();
    test_long_words();
    test_ignored_bytes();
    test_random_lanes();
    test_random_noise();
    lane_bus.valid <= 1'b0;

    stall_pct = 20;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** sensor_lane_word_decoder: PASSED **");
    end else begin
      $display("** sensor_lane_word_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/slwd_pkg.sv
rtl/slwd_lane_if.sv
rtl/slwd_word_if.sv
rtl/slwd_parser.sv
rtl/slwd_out_reg.sv
rtl/sensor_lane_word_decoder.sv
tb/sensor_lane_word_decoder_tb.sv
